FILE: sv/scl_pkg.sv
// Shared constants, codes and types for the serial command line parser.
package scl_pkg;

    localparam int LINE_BUFFER_BYTES = 32;
    localparam int LEN_W  = $clog2(LINE_BUFFER_BYTES);
    localparam int ACC_W  = 10;
    localparam int KIND_W = 4;
    localparam int PCT_W  = 7;

    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_BUFFER_BYTES - 1);
    localparam logic [ACC_W-1:0] PCT_MAX   = ACC_W'(100);

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CASE_GAP = 8'h20;

    localparam logic [KIND_W-1:0] KIND_CUT          = 4'd0;
    localparam logic [KIND_W-1:0] KIND_REARM        = 4'd1;
    localparam logic [KIND_W-1:0] KIND_PROBE        = 4'd2;
    localparam logic [KIND_W-1:0] KIND_STATUS_NOW   = 4'd3;
    localparam logic [KIND_W-1:0] KIND_APP_ON       = 4'd4;
    localparam logic [KIND_W-1:0] KIND_APP_OFF      = 4'd5;
    localparam logic [KIND_W-1:0] KIND_CHARGING_ON  = 4'd6;
    localparam logic [KIND_W-1:0] KIND_CHARGING_OFF = 4'd7;
    localparam logic [KIND_W-1:0] KIND_BATTERY      = 4'd8;
    localparam logic [KIND_W-1:0] KIND_LIMIT        = 4'd9;

    typedef struct packed {
        logic              hit;
        logic [KIND_W-1:0] kind;
        logic [PCT_W-1:0]  pct;
    } t_result;

endpackage

FILE: sv/scl_line_track.sv
// Line state tracking and end-of-line command decode.
module scl_line_track
    import scl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output t_result    o_res
);

    logic [LEN_W-1:0] r_len,    n_len;
    logic             r_ovf,    n_ovf;
    logic [7:0]       r_first,  n_first;
    logic [7:0]       r_second, n_second;
    logic [ACC_W-1:0] r_acc,    n_acc;
    logic             r_dig_ok, n_dig_ok;

    logic             is_digit;
    logic [ACC_W-1:0] digit_val;
    logic [7:0]       tag;

    assign is_digit  = (i_byte >= CH_0) && (i_byte <= CH_9);
    assign digit_val = ACC_W'(i_byte - CH_0);

    // Next line state
    always_comb begin
        n_len    = r_len;
        n_ovf    = r_ovf;
        n_first  = r_first;
        n_second = r_second;
        n_acc    = r_acc;
        n_dig_ok = r_dig_ok;
        if (i_byte == CH_LF) begin
            n_len    = '0;
            n_ovf    = 1'b0;
            n_first  = '0;
            n_second = '0;
            n_acc    = '0;
            n_dig_ok = 1'b1;
        end else if (i_byte != CH_CR) begin
            if (r_len >= LEN_LIMIT) begin
                n_ovf = 1'b1;
            end else begin
                if (r_len == LEN_W'(0)) n_first  = i_byte;
                if (r_len == LEN_W'(1)) n_second = i_byte;
                if (r_len >= LEN_W'(1) && r_len <= LEN_W'(3)) begin
                    if (!is_digit) begin
                        n_dig_ok = 1'b0;
                    end else if (r_dig_ok) begin
                        n_acc = (r_acc << 3) + (r_acc << 1) + digit_val;
                    end
                end
                n_len = r_len + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_ovf    <= 1'b0;
            r_first  <= '0;
            r_second <= '0;
            r_acc    <= '0;
            r_dig_ok <= 1'b1;
        end else if (i_step) begin
            r_len    <= n_len;
            r_ovf    <= n_ovf;
            r_first  <= n_first;
            r_second <= n_second;
            r_acc    <= n_acc;
            r_dig_ok <= n_dig_ok;
        end
    end

    assign tag = (r_first inside {[CH_LO_A:CH_LO_Z]}) ? (r_first - CASE_GAP) : r_first;

    // Decode the stored line when a newline arrives
    always_comb begin
        o_res = '0;
        if (i_byte == CH_LF && !r_ovf && r_len != LEN_W'(0)) begin
            if (r_len == LEN_W'(1)) begin
                case (tag)
                    CH_C:     begin o_res.hit = 1'b1; o_res.kind = KIND_CUT;        end
                    CH_R:     begin o_res.hit = 1'b1; o_res.kind = KIND_REARM;      end
                    CH_P:     begin o_res.hit = 1'b1; o_res.kind = KIND_PROBE;      end
                    CH_QUERY: begin o_res.hit = 1'b1; o_res.kind = KIND_STATUS_NOW; end
                    default:  o_res.hit = 1'b0;
                endcase
            end else if (r_len == LEN_W'(2) && tag == CH_A) begin
                if (r_second == CH_1) begin
                    o_res.hit = 1'b1; o_res.kind = KIND_APP_ON;
                end else if (r_second == CH_0) begin
                    o_res.hit = 1'b1; o_res.kind = KIND_APP_OFF;
                end
            end else if (r_len == LEN_W'(2) && tag == CH_L) begin
                if (r_second == CH_1) begin
                    o_res.hit = 1'b1; o_res.kind = KIND_CHARGING_ON;
                end else if (r_second == CH_0) begin
                    o_res.hit = 1'b1; o_res.kind = KIND_CHARGING_OFF;
                end
            end else if ((tag == CH_B || tag == CH_T) && r_len >= LEN_W'(2)
                         && r_len <= LEN_W'(4)) begin
                if (r_dig_ok && r_acc <= PCT_MAX) begin
                    o_res.hit  = 1'b1;
                    o_res.kind = (tag == CH_B) ? KIND_BATTERY : KIND_LIMIT;
                    o_res.pct  = r_acc[PCT_W-1:0];
                end
            end
        end
    end

endmodule

FILE: sv/serial_command_line_parser.sv
// Top level of the serial command line parser: input register, line tracker, result register.
//
//  channel | valid        | ready        | payload
//  --------+--------------+--------------+----------------------------------
//  rx      | i_rx_valid   | o_rx_ready   | i_rx_byte
//  cmd     | o_cmd_valid  | i_cmd_ready  | o_command_kind, o_percent_value
//
// One item per cycle sustained while the cmd output is not stalled. A byte is
// registered on acceptance and is consumed by the line tracker when the result
// register is free or is being emptied; a newline's command is loaded into the
// result register and shows on the cmd channel from there.
// Reset (i_rst_n low, synchronous) empties both registers and clears the line.
// A stalled cmd output holds the input register; rx stays ready while the
// held byte can move on in the same cycle.
module serial_command_line_parser
    import scl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rx_valid,
    output logic              o_rx_ready,
    input  logic [7:0]        i_rx_byte,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output logic [KIND_W-1:0] o_command_kind,
    output logic [PCT_W-1:0]  o_percent_value
);

    logic              r_byte_v;
    logic [7:0]        r_byte;
    logic              r_cmd_v;
    logic [KIND_W-1:0] r_kind;
    logic [PCT_W-1:0]  r_pct;

    logic    advance;
    t_result res;

    // Move the held byte through the tracker whenever the result slot is free
    // or is being emptied this cycle.
    assign advance    = r_byte_v && (!r_cmd_v || i_cmd_ready);
    assign o_rx_ready = !r_byte_v || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_v <= 1'b0;
        end else if (o_rx_ready) begin
            r_byte_v <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_byte <= i_rx_byte;
        end
    end

    scl_line_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_byte  (r_byte),
        .o_res   (res)
    );

    // Result register: load on a decoded command, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_v <= 1'b0;
        end else if (advance) begin
            r_cmd_v <= res.hit;
        end else if (i_cmd_ready) begin
            r_cmd_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res.hit) begin
            r_kind <= res.kind;
            r_pct  <= res.pct;
        end
    end

    assign o_cmd_valid     = r_cmd_v;
    assign o_command_kind  = r_kind;
    assign o_percent_value = r_pct;

endmodule

FILE: sv/scl_checker.sv
// Port-level checker for the serial command line parser, with its bind.
module scl_checker
    import scl_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_cmd_valid,
    input logic              i_cmd_ready,
    input logic [KIND_W-1:0] o_command_kind,
    input logic [PCT_W-1:0]  o_percent_value
);

    a_cmd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_valid && !i_cmd_ready |=> o_cmd_valid)
        else $error("cmd valid dropped while stalled");

    a_cmd_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_valid && !i_cmd_ready |=> $stable(o_command_kind) && $stable(o_percent_value))
        else $error("cmd payload changed while stalled");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_valid |-> o_command_kind <= KIND_LIMIT)
        else $error("command kind out of range");

    a_pct_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_valid |-> ((o_command_kind == KIND_BATTERY || o_command_kind == KIND_LIMIT)
                         ? (o_percent_value <= PCT_W'(100)) : (o_percent_value == '0)))
        else $error("percent value inconsistent with kind");

    a_reset_empty: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !o_cmd_valid)
        else $error("cmd valid after reset");

endmodule

bind serial_command_line_parser scl_checker u_scl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_cmd_valid     (o_cmd_valid),
    .i_cmd_ready     (i_cmd_ready),
    .o_command_kind  (o_command_kind),
    .o_percent_value (o_percent_value)
);

FILE: bench/scl_command_checker.sv
// Checker for the serial command line parser: predicts commands from received bytes and compares.
module scl_command_checker
    import scl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rx_valid,
    input  logic              i_rx_ready,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_cmd_valid,
    input  logic              i_cmd_ready,
    input  logic [KIND_W-1:0] i_command_kind,
    input  logic [PCT_W-1:0]  i_percent_value,
    output int                o_fail_count,
    output int                o_pending
);

    // Shadow of the line tracker.
    int         line_len;
    logic       overflowed;
    logic [7:0] lead_char;
    logic [7:0] next_char;
    int         digit_value;
    logic       all_digits;

    int         mismatches = 0;
    t_result    expected_cmds[$];

    assign o_fail_count = mismatches;

    function automatic void clear_line();
        line_len    = 0;
        overflowed  = 1'b0;
        lead_char   = 8'h00;
        next_char   = 8'h00;
        digit_value = 0;
        all_digits  = 1'b1;
    endfunction

    function automatic void store_char(input logic [7:0] ch);
        if (line_len >= LINE_BUFFER_BYTES - 1) begin
            overflowed = 1'b1;
            return;
        end
        if (line_len == 0) begin
            lead_char = ch;
        end else if (line_len == 1) begin
            next_char = ch;
        end
        // Positions 1..3 carry the decimal value of B and T lines.
        if (line_len >= 1 && line_len <= 3) begin
            if (ch < CH_0 || ch > CH_9) begin
                all_digits = 1'b0;
            end else if (all_digits) begin
                digit_value = digit_value * 10 + int'(ch - CH_0);
            end
        end
        line_len++;
    endfunction

    function automatic t_result decode_line();
        logic [7:0] tag;
        t_result    res;
        tag = (lead_char >= CH_LO_A && lead_char <= CH_LO_Z) ? lead_char - CASE_GAP : lead_char;
        res = '0;
        if (line_len == 1) begin
            res.hit = 1'b1;
            case (tag)
                CH_C:     res.kind = KIND_CUT;
                CH_R:     res.kind = KIND_REARM;
                CH_P:     res.kind = KIND_PROBE;
                CH_QUERY: res.kind = KIND_STATUS_NOW;
                default:  res.hit = 1'b0;
            endcase
        end else if (line_len == 2 && (tag == CH_A || tag == CH_L)) begin
            res.hit = (next_char == CH_1 || next_char == CH_0);
            if (tag == CH_A) begin
                res.kind = (next_char == CH_1) ? KIND_APP_ON : KIND_APP_OFF;
            end else begin
                res.kind = (next_char == CH_1) ? KIND_CHARGING_ON : KIND_CHARGING_OFF;
            end
        end else if ((tag == CH_B || tag == CH_T) && line_len >= 2 && line_len <= 4) begin
            if (all_digits && digit_value <= 100) begin
                res.hit  = 1'b1;
                res.kind = (tag == CH_B) ? KIND_BATTERY : KIND_LIMIT;
                res.pct  = PCT_W'(digit_value);
            end
        end
        return res;
    endfunction

    function automatic void take_char(input logic [7:0] ch);
        t_result res;
        if (ch == CH_CR) begin
            return;
        end
        if (ch != CH_LF) begin
            store_char(ch);
            return;
        end
        if (!overflowed && line_len != 0) begin
            res = decode_line();
            if (res.hit) begin
                expected_cmds.push_back(res);
            end
        end
        clear_line();
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            clear_line();
            expected_cmds.delete();
            o_pending <= 0;
        end else begin
            // A command leaving now belongs to an older newline, so pop before push.
            if (i_cmd_valid && i_cmd_ready) begin
                if (expected_cmds.size() == 0) begin
                    mismatches++;
                    $error("unexpected command: command_kind %0d, percent_value %0d",
                           i_command_kind, i_percent_value);
                end else begin
                    want = expected_cmds.pop_front();
                    if (i_command_kind !== want.kind) begin
                        mismatches++;
                        $error("command_kind mismatch: expected %0d, actual %0d",
                               want.kind, i_command_kind);
                    end
                    if (i_percent_value !== want.pct) begin
                        mismatches++;
                        $error("percent_value mismatch: expected %0d, actual %0d",
                               want.pct, i_percent_value);
                    end
                end
            end
            if (i_rx_valid && i_rx_ready) begin
                take_char(i_rx_byte);
            end
            o_pending <= expected_cmds.size();
        end
    end

endmodule

FILE: bench/tb_serial_command_line_parser.sv
// Testbench top for the serial command line parser: clock, reset, byte stimulus and verdict.
module tb_serial_command_line_parser;
    import scl_pkg::*;

    localparam int RANDOM_BYTES = 1950;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_rx_valid  = 1'b0;
    logic              o_rx_ready;
    logic [7:0]        i_rx_byte   = 8'h00;
    logic              o_cmd_valid;
    logic              i_cmd_ready = 1'b0;
    logic [KIND_W-1:0] o_command_kind;
    logic [PCT_W-1:0]  o_percent_value;

    int                fail_count;
    int                pending_cmds;

    // Set during the burst window: neither side idles.
    logic              quiet       = 1'b0;
    int                bytes_sent  = 0;
    logic [7:0]        line_bytes[$];

    serial_command_line_parser uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rx_valid      (i_rx_valid),
        .o_rx_ready      (o_rx_ready),
        .i_rx_byte       (i_rx_byte),
        .o_cmd_valid     (o_cmd_valid),
        .i_cmd_ready     (i_cmd_ready),
        .o_command_kind  (o_command_kind),
        .o_percent_value (o_percent_value)
    );

    scl_command_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rx_valid      (i_rx_valid),
        .i_rx_ready      (o_rx_ready),
        .i_rx_byte       (i_rx_byte),
        .i_cmd_valid     (o_cmd_valid),
        .i_cmd_ready     (i_cmd_ready),
        .i_command_kind  (o_command_kind),
        .i_percent_value (o_percent_value),
        .o_fail_count    (fail_count),
        .o_pending       (pending_cmds)
    );

    always #10 i_clk = ~i_clk;

    // Stall the command consumer at random, about 31 percent of the time, except in the burst window.
    always @(posedge i_clk) begin
        i_cmd_ready <= quiet || ($urandom_range(99) >= 31);
    end

    // Hard stop in case the block hangs.
    initial begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Offer one item; hold valid and the byte until the handshake edge.
    task automatic send_byte(input logic [7:0] b);
        if (!quiet) begin
            while ($urandom_range(99) < 31) begin
                i_rx_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_rx_ready);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
        send_byte(CH_LF);
    endtask

    // Drop valid and wait until every predicted command has been taken.
    // The checker posts its count through a register after the handshake, hence the first edge.
    task automatic drain_commands();
        i_rx_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_cmds != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] any_but_lf();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b == CH_LF);
        return b;
    endfunction

    // Push a letter in upper or lower case at random.
    function automatic void push_letter(input logic [7:0] ch);
        line_bytes.push_back(ch | ($urandom_range(1) ? CASE_GAP : 8'h00));
    endfunction

    // Push one to three digits, leading zeros allowed; mostly in range, some above 100.
    function automatic void push_number();
        int v;
        int need;
        int n;
        int div;
        v    = ($urandom_range(9) < 8) ? $urandom_range(100) : $urandom_range(101, 999);
        need = (v >= 100) ? 3 : (v >= 10) ? 2 : 1;
        n    = $urandom_range(need, 3);
        div  = (n == 3) ? 100 : (n == 2) ? 10 : 1;
        while (div > 0) begin
            line_bytes.push_back(CH_0 + 8'((v / div) % 10));
            div = div / 10;
        end
    endfunction

    // Build one random line ending in a newline: mostly valid commands, then
    // malformed commands, overflowing lines, empty lines and raw noise.
    function automatic void build_random_line();
        int pick;
        int n;
        int pos;
        line_bytes.delete();
        pick = $urandom_range(99);
        if (pick < 55) begin
            case ($urandom_range(9))
                0: push_letter(CH_C);
                1: push_letter(CH_R);
                2: push_letter(CH_P);
                3: line_bytes.push_back(CH_QUERY);
                4: begin push_letter(CH_A); line_bytes.push_back(CH_1); end
                5: begin push_letter(CH_A); line_bytes.push_back(CH_0); end
                6: begin push_letter(CH_L); line_bytes.push_back(CH_1); end
                7: begin push_letter(CH_L); line_bytes.push_back(CH_0); end
                default: begin
                    push_letter($urandom_range(1) ? CH_B : CH_T);
                    push_number();
                end
            endcase
        end else if (pick < 67) begin
            case ($urandom_range(3))
                0: begin
                    // B or T with a stray byte among the digits
                    push_letter($urandom_range(1) ? CH_B : CH_T);
                    n = $urandom_range(2);
                    for (int i = 0; i < n; i++)
                        line_bytes.push_back(CH_0 + 8'($urandom_range(9)));
                    line_bytes.push_back(any_but_lf());
                end
                1: begin
                    push_letter($urandom_range(1) ? CH_A : CH_L);
                    line_bytes.push_back(any_but_lf());
                end
                2: line_bytes.push_back(any_but_lf());
                default: begin
                    // four digits: too long for a value
                    push_letter($urandom_range(1) ? CH_B : CH_T);
                    for (int i = 0; i < 4; i++)
                        line_bytes.push_back(CH_0 + 8'($urandom_range(9)));
                end
            endcase
        end else if (pick < 75) begin
            // Straddle the capacity: 31 stored bytes still decode, 32 overflow.
            n = $urandom_range(29, 34);
            if ($urandom_range(1)) push_letter(CH_C);
            while (line_bytes.size() < n) line_bytes.push_back(any_but_lf());
        end else if (pick < 82) begin
            n = $urandom_range(2);
            for (int i = 0; i < n; i++) line_bytes.push_back(CH_CR);
        end else begin
            // Raw noise over the whole byte range, newlines included.
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) line_bytes.push_back(8'($urandom_range(255)));
        end
        // Carriage returns anywhere must not disturb the line.
        if ($urandom_range(99) < 15) begin
            pos = $urandom_range(line_bytes.size());
            line_bytes.insert(pos, CH_CR);
        end
        line_bytes.push_back(CH_LF);
    endfunction

    initial begin
        int lines;
        lines = 0;

        // Hold reset, then release it for good.
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: each single-letter command, both cases, a carriage return,
        // the switches, the upper percent bound and an empty line.
        send_text("c");
        send_byte(CH_R);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_text("p");
        send_text("?");
        send_text("a1");
        send_text("L0");
        send_text("B100");
        send_text("t7");
        send_byte(CH_LF);

        // Random lines; hold both sides busy in one window and drain now and then.
        while (bytes_sent < 24 + RANDOM_BYTES) begin
            quiet = (bytes_sent >= 700 && bytes_sent < 1000);
            build_random_line();
            foreach (line_bytes[i]) send_byte(line_bytes[i]);
            lines++;
            if (lines % 150 == 0) begin
                drain_commands();
            end
        end
        quiet = 1'b0;

        // Wait for every command, then give the pipeline time to show strays.
        drain_commands();
        repeat (10) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: serial_command_line_parser.f
sv/scl_pkg.sv
sv/scl_line_track.sv
sv/serial_command_line_parser.sv
sv/scl_checker.sv
bench/scl_command_checker.sv
bench/tb_serial_command_line_parser.sv
